@@ rtl/assert_macros.svh @@
// Assertion helpers included by the output queue (smp_out_fifo.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define SMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that one condition implies another on the next edge
`define SMP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/smp_pkg.sv @@
package smp_pkg;

  localparam int USERNAME_CAPACITY = 128;
  localparam int REASON_CAPACITY   = 128;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  TOP_BITS_MASK = 8'hC0;
  localparam logic [31:0] MAGIC_COOKIE  = 32'h2112A442;
  localparam logic [4:0]  HDR_BYTES     = 5'd20;
  localparam logic [16:0] POS_MAX       = 17'h1FFFF;

  localparam logic [15:0] AT_XMAP   = 16'h0020;
  localparam logic [15:0] AT_USER   = 16'h0006;
  localparam logic [15:0] AT_INTEG  = 16'h0008;
  localparam logic [15:0] AT_FPRINT = 16'h8028;
  localparam logic [15:0] AT_ERROR  = 16'h0009;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_AHDR   = 3'd1;
  localparam logic [2:0] PH_VALUE  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [2:0] KIND_SUMMARY = 3'd0;
  localparam logic [2:0] KIND_TXID    = 3'd1;
  localparam logic [2:0] KIND_USER    = 3'd2;
  localparam logic [2:0] KIND_INTEG   = 3'd3;
  localparam logic [2:0] KIND_REASON  = 3'd4;

  localparam int FLAG_XMAP   = 0;
  localparam int FLAG_USER   = 1;
  localparam int FLAG_INTEG  = 2;
  localparam int FLAG_FPRINT = 3;
  localparam int FLAG_ERROR  = 4;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  content_byte;
    logic [6:0]  content_index;
    logic        message_valid;
    logic [13:0] message_type;
    logic [15:0] mapped_port_raw;
    logic [31:0] mapped_ip_raw;
    logic [4:0]  present_flags;
    logic [9:0]  error_value;
    logic [31:0] fingerprint_value;
    logic [6:0]  username_length;
    logic [6:0]  reason_length;
  } smp_rec_t;

  // Records produced by one byte: an optional content record, then an
  // optional summary
  typedef struct packed {
    logic     first_vld;
    smp_rec_t first;
    logic     second_vld;
    smp_rec_t second;
  } smp_push_t;

endpackage

@@ rtl/smp_parse_core.sv @@
module smp_parse_core
  import smp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output smp_push_t  push
);

  localparam logic [6:0] USER_CAP   = 7'(USERNAME_CAPACITY - 1);
  localparam logic [6:0] REASON_CAP = 7'(REASON_CAPACITY - 1);

  logic [16:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] at_type_r, at_type_nxt;
  logic [15:0] at_len_r, at_len_nxt;
  logic [16:0] vpos_r, vpos_nxt;
  logic [63:0] vsh_r, vsh_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [31:0] fp_r, fp_nxt;
  logic [9:0]  err_r, err_nxt;
  logic [4:0]  flag_r, flag_nxt;
  logic [6:0]  ucnt_r, ucnt_nxt;
  logic [6:0]  rcnt_r, rcnt_nxt;

  logic [17:0] np;
  logic [18:0] msg_end;
  logic        attr_hdr_over;
  logic [16:0] vp_inc;
  logic [15:0] rlen;
  logic [7:0]  cookie_byte;
  logic [9:0]  cls_scaled;

  assign np            = {1'b0, pos_r} + 18'd1;
  assign msg_end       = 19'(HDR_BYTES) + {3'b000, plen_r};
  // Next attribute header would run past the payload
  assign attr_hdr_over = ({1'b0, np} + 19'd4) > msg_end;
  assign vp_inc        = vpos_r + 17'd1;
  assign cookie_byte   = MAGIC_COOKIE[8 * (3 - int'(pos_r[1:0])) +: 8];

  // Compute next state and the records for this byte
  always_comb begin
    smp_rec_t content;
    smp_rec_t summary;
    logic     content_vld;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    hdr_ok_nxt  = hdr_ok_r;
    plen_nxt    = plen_r;
    type_nxt    = type_r;
    at_type_nxt = at_type_r;
    at_len_nxt  = at_len_r;
    vpos_nxt    = vpos_r;
    vsh_nxt     = vsh_r;
    port_nxt    = port_r;
    ip_nxt      = ip_r;
    fp_nxt      = fp_r;
    err_nxt     = err_r;
    flag_nxt    = flag_r;
    ucnt_nxt    = ucnt_r;
    rcnt_nxt    = rcnt_r;
    content     = '0;
    content_vld = 1'b0;
    summary     = '0;
    rlen        = 16'd0;
    cls_scaled  = 10'd0;

    unique case (phase_r)
      PH_HEADER: begin
        priority if (pos_r == 17'd0) begin
          if ((data_byte & TOP_BITS_MASK) != 8'd0) hdr_ok_nxt = 1'b0;
          type_nxt = {data_byte, 8'd0};
        end else if (pos_r == 17'd1) begin
          type_nxt = {type_r[15:8], data_byte};
        end else if (pos_r == 17'd2) begin
          plen_nxt = {data_byte, 8'd0};
        end else if (pos_r == 17'd3) begin
          plen_nxt = {plen_r[15:8], data_byte};
        end else if (pos_r < 17'd8) begin
          if (cookie_byte != data_byte) hdr_ok_nxt = 1'b0;
        end else begin
          // Stream transaction id bytes
          if (hdr_ok_r) begin
            content_vld           = 1'b1;
            content.record_kind   = KIND_TXID;
            content.content_byte  = data_byte;
            content.content_index = 7'(pos_r - 17'd8);
          end
          if (pos_r >= 17'(HDR_BYTES - 5'd1)) begin
            vpos_nxt = '0;
            if (hdr_ok_r && !attr_hdr_over) phase_nxt = PH_AHDR;
            else phase_nxt = PH_DONE;
          end
        end
      end
      PH_AHDR: begin
        unique case (vpos_r[1:0])
          2'd0: at_type_nxt = {data_byte, 8'd0};
          2'd1: at_type_nxt = {at_type_r[15:8], data_byte};
          2'd2: at_len_nxt  = {data_byte, 8'd0};
          2'd3: at_len_nxt  = {at_len_r[15:8], data_byte};
        endcase
        vpos_nxt = vp_inc;
        if (vp_inc >= 17'd4) begin
          priority if (({1'b0, np} + {3'b000, at_len_nxt}) > msg_end) begin
            phase_nxt = PH_DONE;
          end else if (at_len_nxt == 16'd0) begin
            vpos_nxt  = '0;
            phase_nxt = attr_hdr_over ? PH_DONE : PH_AHDR;
          end else begin
            phase_nxt = PH_VALUE;
            vpos_nxt  = '0;
            vsh_nxt   = '0;
            if (at_type_nxt == AT_USER) begin
              flag_nxt[FLAG_USER] = 1'b1;
              ucnt_nxt = (at_len_nxt < 16'(USER_CAP)) ? at_len_nxt[6:0] : USER_CAP;
            end else if (at_type_nxt == AT_ERROR && at_len_nxt > 16'd4) begin
              rlen     = at_len_nxt - 16'd4;
              rcnt_nxt = (rlen < 16'(REASON_CAP)) ? rlen[6:0] : REASON_CAP;
            end
          end
        end
      end
      PH_VALUE: begin
        if (vpos_r < 17'd8) vsh_nxt = {vsh_r[55:0], data_byte};
        priority if (at_type_r == AT_USER) begin
          if (vpos_r < 17'(USER_CAP)) begin
            content_vld           = 1'b1;
            content.record_kind   = KIND_USER;
            content.content_byte  = data_byte;
            content.content_index = vpos_r[6:0];
          end
        end else if (at_type_r == AT_INTEG) begin
          if (at_len_r == 16'd20) begin
            flag_nxt[FLAG_INTEG]  = 1'b1;
            content_vld           = 1'b1;
            content.record_kind   = KIND_INTEG;
            content.content_byte  = data_byte;
            content.content_index = vpos_r[6:0];
          end
        end else if (at_type_r == AT_FPRINT) begin
          if (at_len_r == 16'd4 && vpos_r == 17'd3) begin
            fp_nxt                 = vsh_nxt[31:0];
            flag_nxt[FLAG_FPRINT]  = 1'b1;
          end
        end else if (at_type_r == AT_ERROR) begin
          if (vpos_r == 17'd3) begin
            cls_scaled           = {7'd0, vsh_nxt[10:8]} * 10'd100;
            err_nxt              = cls_scaled + {2'b00, vsh_nxt[7:0]};
            flag_nxt[FLAG_ERROR] = 1'b1;
          end else if (vpos_r >= 17'd4 && (vpos_r - 17'd4) < 17'(REASON_CAP)) begin
            content_vld           = 1'b1;
            content.record_kind   = KIND_REASON;
            content.content_byte  = data_byte;
            content.content_index = 7'(vpos_r - 17'd4);
          end
        end else if (at_type_r == AT_XMAP) begin
          if (vpos_r == 17'd7 && vsh_nxt[55:48] == 8'd1) begin
            port_nxt            = vsh_nxt[47:32];
            ip_nxt              = vsh_nxt[31:0];
            flag_nxt[FLAG_XMAP] = 1'b1;
          end
        end else begin
        end
        vpos_nxt = vp_inc;
        // End of value: pad to a word, or start the next attribute or finish the message
        if (vp_inc >= {1'b0, at_len_r}) begin
          if (at_len_r[1:0] != 2'd0) begin
            phase_nxt = PH_PAD;
            vpos_nxt  = {15'd0, 2'd0 - at_len_r[1:0]};
          end else begin
            vpos_nxt  = '0;
            phase_nxt = attr_hdr_over ? PH_DONE : PH_AHDR;
          end
        end
      end
      PH_PAD: begin
        if (vpos_r > 17'd0) vpos_nxt = vpos_r - 17'd1;
        if (vpos_nxt == 17'd0) begin
          phase_nxt = attr_hdr_over ? PH_DONE : PH_AHDR;
        end
      end
      default: begin
      end
    endcase

    pos_nxt = (np > {1'b0, POS_MAX}) ? POS_MAX : np[16:0];

    // Build the summary from the updated fields
    summary.record_kind       = KIND_SUMMARY;
    summary.message_valid     = hdr_ok_nxt && (np >= 18'(HDR_BYTES))
                                && ({1'b0, np} >= msg_end);
    summary.message_type      = type_nxt[13:0];
    summary.mapped_port_raw   = port_nxt;
    summary.mapped_ip_raw     = ip_nxt;
    summary.present_flags     = flag_nxt;
    summary.error_value       = err_nxt;
    summary.fingerprint_value = fp_nxt;
    summary.username_length   = ucnt_nxt;
    summary.reason_length     = rcnt_nxt;

    push.first_vld  = byte_accept && (content_vld || last_byte);
    push.first      = content_vld ? content : summary;
    push.second_vld = byte_accept && content_vld && last_byte;
    push.second     = summary;
  end

  // Advance the parse state; clear all fields on reset or after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_accept && last_byte)) begin
      pos_r     <= '0;
      phase_r   <= PH_HEADER;
      hdr_ok_r  <= 1'b1;
      plen_r    <= '0;
      type_r    <= '0;
      at_type_r <= '0;
      at_len_r  <= '0;
      vpos_r    <= '0;
      vsh_r     <= '0;
      port_r    <= '0;
      ip_r      <= '0;
      fp_r      <= '0;
      err_r     <= '0;
      flag_r    <= '0;
      ucnt_r    <= '0;
      rcnt_r    <= '0;
    end else if (byte_accept) begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      hdr_ok_r  <= hdr_ok_nxt;
      plen_r    <= plen_nxt;
      type_r    <= type_nxt;
      at_type_r <= at_type_nxt;
      at_len_r  <= at_len_nxt;
      vpos_r    <= vpos_nxt;
      vsh_r     <= vsh_nxt;
      port_r    <= port_nxt;
      ip_r      <= ip_nxt;
      fp_r      <= fp_nxt;
      err_r     <= err_nxt;
      flag_r    <= flag_nxt;
      ucnt_r    <= ucnt_nxt;
      rcnt_r    <= rcnt_nxt;
    end
  end

endmodule

@@ rtl/smp_out_fifo.sv @@
`include "assert_macros.svh"

module smp_out_fifo
  import smp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  smp_push_t push,
  output logic      room2,
  output logic      out_vld,
  output smp_rec_t  out_rec,
  input  logic      out_rdy
);

  localparam logic [FIFO_AW:0] DEPTH_C = (FIFO_AW + 1)'(FIFO_DEPTH);

  smp_rec_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]    count_r, count_nxt;
  logic [1:0]          push_n;
  logic                pop;

  assign room2   = count_r <= (DEPTH_C - (FIFO_AW + 1)'(2));
  assign out_vld = count_r != '0;
  assign out_rec = mem_r[rd_ptr_r];
  assign pop     = out_vld && out_rdy;
  assign push_n  = {1'b0, push.first_vld} + {1'b0, push.second_vld};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
  end

  // Write up to two records per cycle
  always_ff @(posedge clk) begin
    if (push.first_vld) mem_r[wr_ptr_r] <= push.first;
    if (push.second_vld) mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.second;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SMP_ASSERT(a_no_overflow, count_r <= DEPTH_C, "output queue overflow")
  `SMP_ASSERT(a_push_has_room, (push_n != 2'd0) |-> room2, "push without room")
  `SMP_ASSERT_NEXT(a_second_needs_first, push.second_vld, count_r >= (FIFO_AW + 1)'(2), "second record pushed alone")

endmodule

@@ rtl/stun_message_parser_top.sv @@
// Accepted bytes' records enter a four-entry output queue behind any still waiting.
// Throughput: one byte per cycle while the queue has room; the last byte of a message
// with a content record yields two records, drained one per cycle while out_ready is high.
// The input stalls only when that queue has fewer than two free slots.
// Reset: synchronous, active low; clears the parser to the header phase and empties the queue.
module stun_message_parser_top
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_record_kind,
  output logic [7:0]  out_content_byte,
  output logic [6:0]  out_content_index,
  output logic        out_message_valid,
  output logic [13:0] out_message_type,
  output logic [15:0] out_mapped_port_raw,
  output logic [31:0] out_mapped_ip_raw,
  output logic [4:0]  out_present_flags,
  output logic [9:0]  out_error_value,
  output logic [31:0] out_fingerprint_value,
  output logic [6:0]  out_username_length,
  output logic [6:0]  out_reason_length
);

  smp_push_t push;
  smp_rec_t  rec;
  logic      room2;

  assign in_ready = room2;

  smp_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_valid && in_ready),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .push        (push)
  );

  smp_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room2   (room2),
    .out_vld (out_valid),
    .out_rec (rec),
    .out_rdy (out_ready)
  );

  assign out_record_kind       = rec.record_kind;
  assign out_content_byte      = rec.content_byte;
  assign out_content_index     = rec.content_index;
  assign out_message_valid     = rec.message_valid;
  assign out_message_type      = rec.message_type;
  assign out_mapped_port_raw   = rec.mapped_port_raw;
  assign out_mapped_ip_raw     = rec.mapped_ip_raw;
  assign out_present_flags     = rec.present_flags;
  assign out_error_value       = rec.error_value;
  assign out_fingerprint_value = rec.fingerprint_value;
  assign out_username_length   = rec.username_length;
  assign out_reason_length     = rec.reason_length;

endmodule
